// ----- rtl/ldmpq_pkg.sv -----
//------------------------------------------------------------------------------
// ldmpq_pkg
// Shared types and constants for the lazy-deletion max priority queue.
//------------------------------------------------------------------------------
`default_nettype none

package ldmpq_pkg;

  localparam int unsigned CapacityDefault = 1024;
  localparam int unsigned ValueWidth      = 32;
  localparam int unsigned CountWidth      = 11;

  typedef enum logic [1:0] {
    OP_PUSH  = 2'd0,
    OP_ERASE = 2'd1,
    OP_TOP   = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_UP_RD,
    ST_UP_CMP,
    ST_TOP_RD,
    ST_TOP_CMP,
    ST_DN_LAST,
    ST_DN_RD,
    ST_DN_CMP,
    ST_DN_PICK,
    ST_DONE
  } state_e;

endpackage

`default_nettype wire

// ----- rtl/lazy_delete_max_priority_queue.sv -----
//------------------------------------------------------------------------------
// lazy_delete_max_priority_queue
// Max priority queue from two binary max-heaps (main and erased) in RAM.
//------------------------------------------------------------------------------
//  channel | direction | signals
//  in      | input     | in_valid_i, in_stall_o, op_i, value_i
//  out     | output    | out_valid_o, out_stall_i, top_value_o, top_valid_o,
//          |           | live_count_o, overflow_o
//
// One transaction at a time. Push/erase append the value, then climb it one
// level per UP_RD/UP_CMP pass. Read top compares the roots (TOP_RD, TOP_CMP);
// each cancelled pair goes by a sift-down of each heap (DN_LAST, DN_RD/CMP/PICK).
// Reset clears counts and control only; heap RAMs need no clearing.
// A result waits in the output register while the next transaction runs;
// a finished transaction holds in DONE while the previous result is stalled.
`default_nettype none

module lazy_delete_max_priority_queue #(
  parameter int unsigned CAPACITY = ldmpq_pkg::CapacityDefault
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [1:0]  op_i,
  input  wire logic signed [31:0] value_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic signed [31:0] top_value_o,
  output logic             top_valid_o,
  output logic [10:0]      live_count_o,
  output logic             overflow_o
);

  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned AW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] CapMax = CW'(CAPACITY);

  typedef logic signed [31:0] val_t;

  // Heap RAMs, 1-based addressing; sel 0 main, sel 1 erased
  val_t mem_main [CAPACITY+1];
  val_t mem_ers  [CAPACITY+1];

  logic          we_m, we_e;
  logic [AW-1:0] wa_m, wa_e, ra_m, ra_e;
  val_t          wd_m, wd_e, rd_m, rd_e;

  always_ff @(posedge clk_i) begin
    if (we_m) mem_main[wa_m] <= wd_m;
    rd_m <= mem_main[ra_m];
  end
  always_ff @(posedge clk_i) begin
    if (we_e) mem_ers[wa_e] <= wd_e;
    rd_e <= mem_ers[ra_e];
  end

  ldmpq_pkg::state_e state_q, state_d;
  logic [CW-1:0] cnt_m_q, cnt_m_d, cnt_e_q, cnt_e_d;
  logic          sel_q, sel_d;           // heap being sifted
  logic [AW-1:0] idx_q, idx_d;           // current node
  logic [AW-1:0] chl_q, chl_d;           // chosen child
  val_t          val_q, val_d;           // value travelling
  val_t          tmp_q, tmp_d;           // first (left) child value
  logic          second_q, second_d;     // erased heap pending sift-down
  logic          ovf_q, ovf_d;
  logic          ovld_q, ovld_d;
  val_t          otop_q, otop_d;         // top of the running transaction
  logic          otv_q, otv_d;
  logic          ovfo_q, ovfo_d;
  val_t          top_o_q, top_o_d;       // result register
  logic          tv_o_q, tv_o_d;
  logic          lastcap_q;              // last entry arrives on rd this cycle
  logic [10:0]   live_q;

  logic [CW-1:0] cnt_sel;
  val_t          rd_sel;
  logic [AW:0]   left;
  logic          res_load;

  assign cnt_sel  = sel_q ? cnt_e_q : cnt_m_q;
  assign rd_sel   = sel_q ? rd_e : rd_m;
  assign left     = {idx_q, 1'b0};
  assign res_load = (state_q == ldmpq_pkg::ST_DONE) && !(ovld_q && out_stall_i);

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ldmpq_pkg::ST_IDLE:
        if (in_valid_i) begin
          unique case (ldmpq_pkg::op_e'(op_i))
            ldmpq_pkg::OP_PUSH:
              state_d = (cnt_m_q >= CapMax) ? ldmpq_pkg::ST_DONE : ldmpq_pkg::ST_UP_RD;
            ldmpq_pkg::OP_ERASE:
              state_d = (cnt_e_q >= CapMax) ? ldmpq_pkg::ST_DONE : ldmpq_pkg::ST_UP_RD;
            ldmpq_pkg::OP_TOP:  state_d = ldmpq_pkg::ST_TOP_RD;
            default:            state_d = ldmpq_pkg::ST_DONE;
          endcase
        end
      ldmpq_pkg::ST_UP_RD:
        state_d = (idx_q <= AW'(1)) ? ldmpq_pkg::ST_DONE : ldmpq_pkg::ST_UP_CMP;
      ldmpq_pkg::ST_UP_CMP:
        state_d = (val_q > rd_sel) ? ldmpq_pkg::ST_UP_RD : ldmpq_pkg::ST_DONE;
      ldmpq_pkg::ST_TOP_RD: state_d = ldmpq_pkg::ST_TOP_CMP;
      ldmpq_pkg::ST_TOP_CMP:
        state_d = (cnt_e_q != '0 && cnt_m_q != '0 && rd_m == rd_e) ?
                  ldmpq_pkg::ST_DN_LAST : ldmpq_pkg::ST_DONE;
      ldmpq_pkg::ST_DN_LAST: state_d = ldmpq_pkg::ST_DN_RD;
      ldmpq_pkg::ST_DN_RD:
        state_d = (left <= {1'b0, cnt_sel}) ? ldmpq_pkg::ST_DN_CMP :
                  (second_q ? ldmpq_pkg::ST_DN_LAST : ldmpq_pkg::ST_TOP_RD);
      ldmpq_pkg::ST_DN_CMP:  state_d = ldmpq_pkg::ST_DN_PICK;
      ldmpq_pkg::ST_DN_PICK: begin
        if (((chl_q != left[AW-1:0]) ? rd_sel > tmp_q ? rd_sel : tmp_q : tmp_q) > val_q
            || ((chl_q != left[AW-1:0]) && rd_sel > val_q))
          state_d = ldmpq_pkg::ST_DN_RD;
        else
          state_d = second_q ? ldmpq_pkg::ST_DN_LAST : ldmpq_pkg::ST_TOP_RD;
      end
      ldmpq_pkg::ST_DONE:
        state_d = (ovld_q && out_stall_i) ? ldmpq_pkg::ST_DONE : ldmpq_pkg::ST_IDLE;
      default: state_d = ldmpq_pkg::ST_IDLE;
    endcase
  end

  // Datapath and memory control
  always_comb begin
    cnt_m_d = cnt_m_q; cnt_e_d = cnt_e_q;
    sel_d = sel_q; idx_d = idx_q; chl_d = chl_q; val_d = val_q; tmp_d = tmp_q;
    second_d = second_q; ovf_d = ovf_q;
    ovld_d = ovld_q && out_stall_i;
    otop_d = otop_q; otv_d = otv_q; ovfo_d = ovfo_q;
    top_o_d = top_o_q; tv_o_d = tv_o_q;
    we_m = 1'b0; we_e = 1'b0;
    wa_m = idx_q; wa_e = idx_q; wd_m = val_q; wd_e = val_q;
    ra_m = AW'(1); ra_e = AW'(1);
    unique case (state_q)
      ldmpq_pkg::ST_IDLE:
        if (in_valid_i) begin
          ovf_d = 1'b0; otv_d = 1'b0; otop_d = '0;
          val_d = value_i;
          sel_d = (op_i == ldmpq_pkg::OP_ERASE);
          if (op_i == ldmpq_pkg::OP_PUSH) begin
            if (cnt_m_q >= CapMax) ovf_d = 1'b1;
            else begin
              cnt_m_d = cnt_m_q + CW'(1); idx_d = AW'(cnt_m_q + CW'(1));
              we_m = 1'b1; wa_m = AW'(cnt_m_q + CW'(1)); wd_m = value_i;
            end
          end else if (op_i == ldmpq_pkg::OP_ERASE) begin
            if (cnt_e_q >= CapMax) ovf_d = 1'b1;
            else begin
              cnt_e_d = cnt_e_q + CW'(1); idx_d = AW'(cnt_e_q + CW'(1));
              we_e = 1'b1; wa_e = AW'(cnt_e_q + CW'(1)); wd_e = value_i;
            end
          end
        end
      ldmpq_pkg::ST_UP_RD: begin
        ra_m = idx_q >> 1; ra_e = idx_q >> 1;
        // value has climbed to the root: store it there
        if (idx_q <= AW'(1)) begin
          we_m = !sel_q; we_e = sel_q;
        end
      end
      ldmpq_pkg::ST_UP_CMP:
        if (val_q > rd_sel) begin
          // swap with parent: parent value down, travelling value up
          we_m = !sel_q; we_e = sel_q;
          wd_m = rd_sel; wd_e = rd_sel;
          wa_m = idx_q; wa_e = idx_q;
          idx_d = idx_q >> 1;
        end else begin
          we_m = !sel_q; we_e = sel_q;
        end
      ldmpq_pkg::ST_TOP_RD: ;
      ldmpq_pkg::ST_TOP_CMP:
        if (cnt_e_q != '0 && cnt_m_q != '0 && rd_m == rd_e) begin
          sel_d = 1'b0; second_d = 1'b1;
        end else begin
          otv_d = (cnt_m_q != '0);
          otop_d = (cnt_m_q != '0) ? rd_m : '0;
        end
      ldmpq_pkg::ST_DN_LAST: begin
        // fetch last entry of selected heap
        ra_m = AW'(cnt_m_q); ra_e = AW'(cnt_e_q);
        if (sel_q) cnt_e_d = cnt_e_q - CW'(1);
        else       cnt_m_d = cnt_m_q - CW'(1);
        idx_d = AW'(1);
      end
      ldmpq_pkg::ST_DN_RD: begin
        ra_m = left[AW-1:0]; ra_e = left[AW-1:0];
        chl_d = left[AW-1:0];
        // right after the last-entry fetch the value is still on rd
        if (lastcap_q) begin
          wd_m = rd_sel; wd_e = rd_sel;
        end
        if (left > {1'b0, cnt_sel}) begin
          we_m = !sel_q; we_e = sel_q;
          if (second_q) begin
            sel_d = 1'b1; second_d = 1'b0;
          end
        end
      end
      ldmpq_pkg::ST_DN_CMP: begin
        tmp_d = rd_sel;
        if (left + (AW+1)'(1) <= {1'b0, cnt_sel}) begin
          ra_m = left[AW-1:0] + AW'(1); ra_e = left[AW-1:0] + AW'(1);
          chl_d = left[AW-1:0] + AW'(1);
        end
      end
      ldmpq_pkg::ST_DN_PICK: begin
        // right child read only when it exists and chl points to it
        if ((chl_q != left[AW-1:0]) && rd_sel > tmp_q) begin
          if (rd_sel > val_q) begin
            we_m = !sel_q; we_e = sel_q; wd_m = rd_sel; wd_e = rd_sel;
            idx_d = chl_q;
          end else begin
            we_m = !sel_q; we_e = sel_q;
          end
        end else if (tmp_q > val_q) begin
          we_m = !sel_q; we_e = sel_q; wd_m = tmp_q; wd_e = tmp_q;
          idx_d = left[AW-1:0];
        end else begin
          we_m = !sel_q; we_e = sel_q;
        end
        if (!(((chl_q != left[AW-1:0]) && rd_sel > tmp_q) ? rd_sel > val_q : tmp_q > val_q)
            && second_q) begin
          sel_d = 1'b1; second_d = 1'b0;
        end
      end
      ldmpq_pkg::ST_DONE:
        // hand the result over once the output register is free
        if (res_load) begin
          ovld_d = 1'b1; ovfo_d = ovf_q; top_o_d = otop_q; tv_o_d = otv_q;
        end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ldmpq_pkg::ST_IDLE;
      cnt_m_q <= '0; cnt_e_q <= '0;
      ovld_q <= 1'b0; second_q <= 1'b0; sel_q <= 1'b0; lastcap_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_m_q <= cnt_m_d; cnt_e_q <= cnt_e_d;
      ovld_q <= ovld_d; second_q <= second_d; sel_q <= sel_d;
      lastcap_q <= (state_q == ldmpq_pkg::ST_DN_LAST);
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d; chl_q <= chl_d; tmp_q <= tmp_d;
    ovf_q <= ovf_d; otop_q <= otop_d; otv_q <= otv_d; ovfo_q <= ovfo_d;
    top_o_q <= top_o_d; tv_o_q <= tv_o_d;
    val_q <= lastcap_q ? rd_sel : val_d;
  end

  // Live count, saturated at zero
  logic [CW-1:0] live;
  assign live = (cnt_m_q >= cnt_e_q) ? cnt_m_q - cnt_e_q : '0;
  always_ff @(posedge clk_i) begin
    if (res_load) live_q <= 11'(live);
  end

  assign in_stall_o   = (state_q != ldmpq_pkg::ST_IDLE);
  assign out_valid_o  = ovld_q;
  assign top_value_o  = top_o_q;
  assign top_valid_o  = tv_o_q;
  assign live_count_o = live_q;
  assign overflow_o   = ovfo_q;

  // Assertions
  a_cnt_m: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_m_q <= CapMax) else $error("main count above capacity");
  a_cnt_e: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_e_q <= CapMax) else $error("erased count above capacity");
  a_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ldmpq_pkg::ST_DONE |=> out_valid_o) else $error("result lost");
  a_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> state_q != ldmpq_pkg::ST_IDLE)
    else $error("transaction dropped");

endmodule

`default_nettype wire
